// File: rtl/core/rrsem_pkg.sv
package rrsem_pkg;

    localparam int SEG_W      = 10;
    localparam int CENTER_W   = 11;
    localparam int MASK_W     = 8;
    localparam int CFG_W      = 10;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam int ROW_PIXELS_DEF = 640;
    localparam int OUTQ_DEPTH     = 4;

    // register index taken from paddr[2]
    localparam logic REG_MIN_RUN_WIDTH = 1'b0;
    localparam logic REG_MAX_MERGE_GAP = 1'b1;

    localparam logic [CFG_W-1:0] MIN_RUN_WIDTH_RST = CFG_W'(5);
    localparam logic [CFG_W-1:0] MAX_MERGE_GAP_RST = CFG_W'(10);

    typedef struct packed {
        logic [MASK_W-1:0] mask_value;
        logic              row_end;
    } t_in;

    typedef struct packed {
        logic                seg_valid;
        logic [SEG_W-1:0]    seg_left;
        logic [SEG_W-1:0]    seg_right;
        logic [SEG_W-1:0]    seg_width;
        logic [CENTER_W-1:0] center_doubled;
        logic                row_last;
    } t_out;

    typedef struct packed {
        logic [CFG_W-1:0] min_run_width;
        logic [CFG_W-1:0] max_merge_gap;
    } t_cfg;

    // up to two results per pixel, slot 0 first
    typedef struct packed {
        logic v0;
        t_out r0;
        logic v1;
        t_out r1;
    } t_push;

    function automatic t_out make_seg(input logic valid,
                                      input logic [CENTER_W-1:0] left,
                                      input logic [CENTER_W-1:0] right,
                                      input logic last);
        t_out             res;
        logic [SEG_W-1:0] w;
        w = right[SEG_W-1:0] - left[SEG_W-1:0] + SEG_W'(1);
        res = '0;
        if (valid) begin
            res.seg_valid      = 1'b1;
            res.seg_left       = left[SEG_W-1:0];
            res.seg_right      = right[SEG_W-1:0];
            res.seg_width      = w;
            res.center_doubled = left + right;
        end
        res.row_last = last;
        return res;
    endfunction

endpackage

// File: rtl/core/rrsem_cfg.sv
module rrsem_cfg
    import rrsem_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_run_width <= MIN_RUN_WIDTH_RST;
            r_cfg.max_merge_gap <= MAX_MERGE_GAP_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MIN_RUN_WIDTH: r_cfg.min_run_width <= pwdata[CFG_W-1:0];
                REG_MAX_MERGE_GAP: r_cfg.max_merge_gap <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_RUN_WIDTH: prdata = APB_DW'(r_cfg.min_run_width);
            REG_MAX_MERGE_GAP: prdata = APB_DW'(r_cfg.max_merge_gap);
            default:           prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/rrsem_core.sv
module rrsem_core
    import rrsem_pkg::*;
#(
    parameter int ROW_PIXELS = ROW_PIXELS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_in   i_in_data,
    input  t_cfg  i_cfg,
    input  logic  i_room,
    output t_push o_push
);

    localparam int COL_W = $clog2(ROW_PIXELS);
    localparam int AW    = ((COL_W > SEG_W) ? COL_W : SEG_W) + 2;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_PIXELS - 1);

    logic             r_in_valid;
    t_in              r_in;
    logic [COL_W-1:0] r_column;
    logic             r_in_run;
    logic [COL_W-1:0] r_run_start;
    logic             r_pend_valid;
    logic [COL_W-1:0] r_pend_left;
    logic [COL_W-1:0] r_pend_right;

    logic             fire;
    logic             active;
    logic             last;
    logic             run_begin;
    logic             run_end;
    logic             run_open;
    logic             do_close;
    logic [COL_W-1:0] cl_left;
    logic [COL_W-1:0] cl_right;
    logic [AW-1:0]    run_w;
    logic             keep;
    logic signed [AW-1:0] gap;
    logic             merge;
    logic             disp;
    logic             n_pend_valid;
    logic [COL_W-1:0] n_pend_left;
    logic [COL_W-1:0] n_pend_right;

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_comb begin
        active    = r_in.mask_value != '0;
        last      = r_in.row_end || (r_column >= LAST_COL);
        run_begin = active && !r_in_run;
        run_end   = !active && r_in_run;
        run_open  = run_begin || (r_in_run && active);
        // a run closes at its first clear pixel, or at the row's last pixel
        do_close  = run_end || (last && run_open);
        cl_left   = run_begin ? r_column : r_run_start;
        cl_right  = run_end ? (r_column - COL_W'(1)) : r_column;
        run_w     = AW'(cl_right) - AW'(cl_left) + AW'(1);
        keep      = run_w >= AW'(i_cfg.min_run_width);
        gap       = $signed(AW'(cl_left)) - $signed(AW'(r_pend_right));
        merge     = r_pend_valid && (gap <= $signed(AW'(i_cfg.max_merge_gap)));

        disp         = 1'b0;
        n_pend_valid = r_pend_valid;
        n_pend_left  = r_pend_left;
        n_pend_right = r_pend_right;
        if (do_close && keep) begin
            if (merge) begin
                n_pend_right = cl_right;
            end else begin
                disp         = r_pend_valid;
                n_pend_valid = 1'b1;
                n_pend_left  = cl_left;
                n_pend_right = cl_right;
            end
        end
    end

    // displaced segment goes out ahead of the row flush
    always_comb begin
        t_out disp_res;
        t_out fin_res;
        disp_res = make_seg(1'b1, CENTER_W'(r_pend_left), CENTER_W'(r_pend_right), 1'b0);
        fin_res  = make_seg(n_pend_valid, CENTER_W'(n_pend_left),
                            CENTER_W'(n_pend_right), 1'b1);
        o_push.v0 = fire && (disp || last);
        o_push.r0 = disp ? disp_res : fin_res;
        o_push.v1 = fire && disp && last;
        o_push.r1 = fin_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_in_run     <= 1'b0;
            r_run_start  <= '0;
            r_pend_valid <= 1'b0;
            r_pend_left  <= '0;
            r_pend_right <= '0;
        end else if (fire) begin
            if (last) begin
                r_column     <= '0;
                r_in_run     <= 1'b0;
                r_run_start  <= '0;
                r_pend_valid <= 1'b0;
                r_pend_left  <= '0;
                r_pend_right <= '0;
            end else begin
                r_column     <= r_column + COL_W'(1);
                r_in_run     <= active;
                r_run_start  <= cl_left;
                r_pend_valid <= n_pend_valid;
                r_pend_left  <= n_pend_left;
                r_pend_right <= n_pend_right;
            end
        end
    end

endmodule

// File: rtl/core/rrsem_outq.sv
module rrsem_outq
    import rrsem_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_out  o_out_data
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    t_out             r_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;
    logic [CNT_W-1:0] n_pushes;
    logic [PTR_W-1:0] wptr_p1;

    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_mem[r_rptr];
    assign pop         = o_out_valid && i_out_ready;
    // room for a full two-result transaction
    assign o_room      = r_count <= CNT_W'(OUTQ_DEPTH - 2);
    assign n_pushes    = CNT_W'(i_push.v0) + CNT_W'(i_push.v1);
    assign wptr_p1     = r_wptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wptr_p1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(n_pushes);
            r_rptr  <= r_rptr + PTR_W'(pop);
            r_count <= r_count + n_pushes - CNT_W'(pop);
        end
    end

endmodule

// File: rtl/core/row_run_segment_extract_merge_unit.sv
// a pixel is registered at acceptance; its results enter the output queue when it
// fires, which waits for room. Throughput: one pixel per cycle while the queue has
// room; a row end can yield two results, drained one per cycle while i_out_ready is
// high, through a four-entry queue that holds o_in_ready low below two free slots
// reset: synchronous active-low i_rst_n clears row state and queue, and loads
// min_run_width 5 and max_merge_gap 10
module row_run_segment_extract_merge_unit
    import rrsem_pkg::*;
#(
    parameter int ROW_PIXELS = ROW_PIXELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg  cfg;
    t_push push;
    logic  room;

    rrsem_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rrsem_core #(
        .ROW_PIXELS (ROW_PIXELS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_room     (room),
        .o_push     (push)
    );

    rrsem_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
